// ----- rtl/irc_line_framer_tokenizer_assert.svh -----
// ---------------------------------------------------------------------------
// irc line framer tokenizer assertion macros
// shared concurrent check forms, sampled on clk, off while arst_n is low
// ---------------------------------------------------------------------------
`ifndef IRC_LINE_FRAMER_TOKENIZER_ASSERT_SVH
`define IRC_LINE_FRAMER_TOKENIZER_ASSERT_SVH

// same-cycle implication
`define ILFT_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// next-cycle implication
`define ILFT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ----- rtl/ilft_pkg.sv -----
// ---------------------------------------------------------------------------
// ilft_pkg
// shared types and constants of the irc line framer tokenizer
// ---------------------------------------------------------------------------
package ilft_pkg;

	typedef enum logic [6:0] {
		PH_START  = 7'b0000001,
		PH_NICK   = 7'b0000010,
		PH_USER   = 7'b0000100,
		PH_HOST   = 7'b0001000,
		PH_CMD    = 7'b0010000,
		PH_MIDDLE = 7'b0100000,
		PH_TRAIL  = 7'b1000000
	} phase_t;

	localparam logic [2:0] TAG_NICK   = 3'd0;
	localparam logic [2:0] TAG_USER   = 3'd1;
	localparam logic [2:0] TAG_HOST   = 3'd2;
	localparam logic [2:0] TAG_CMD    = 3'd3;
	localparam logic [2:0] TAG_MIDDLE = 3'd4;
	localparam logic [2:0] TAG_TRAIL  = 3'd5;
	localparam logic [2:0] TAG_DELIM  = 3'd6;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_LONG  = 2'd1;
	localparam logic [1:0] ST_NOCMD = 2'd2;

	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_AT    = 8'h40;

	localparam int unsigned LIMIT_W = 12;
	localparam int unsigned LEN_W   = 13;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 12'd512;
	localparam logic [LEN_W-1:0]   LEN_SAT     = 13'h1fff;

	localparam logic REG_MAX_LINE_LENGTH = 1'b0;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [2:0] field_tag;
		logic       end_of_line;
		logic [1:0] line_status;
	} result_t;

	typedef struct packed {
		logic    push;
		result_t entry;
	} queue_wr_t;

endpackage

// ----- rtl/ilft_front.sv -----
// ---------------------------------------------------------------------------
// ilft_front
// holds one byte, tags it against the next one, tracks phase and line length
// ---------------------------------------------------------------------------
module ilft_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  logic [7:0]                  in_byte,
	input  logic [ilft_pkg::LIMIT_W-1:0] max_line_length,
	output ilft_pkg::queue_wr_t         wr
);
	import ilft_pkg::*;

	logic [7:0]       held_q;
	logic             held_valid_q;
	phase_t           phase_q;
	phase_t           phase_n;
	logic [LEN_W-1:0] len_q;
	logic [LEN_W-1:0] len_inc;
	logic             ovf_q;
	logic             over;
	logic             is_eol;
	logic             in_prefix;
	logic [2:0]       tag;
	logic [1:0]       status;

	always_comb begin
		phase_n = phase_q;
		tag     = TAG_CMD;
		case (phase_q)
			PH_START: begin
				if (held_q == CH_COLON) begin
					phase_n = PH_NICK;
					tag     = TAG_DELIM;
				end else if (held_q == CH_SPACE) begin
					phase_n = PH_MIDDLE;
					tag     = TAG_DELIM;
				end else begin
					phase_n = PH_CMD;
					tag     = TAG_CMD;
				end
			end
			PH_NICK, PH_USER, PH_HOST: begin
				if (held_q == CH_BANG) begin
					phase_n = PH_USER;
					tag     = TAG_DELIM;
				end else if (held_q == CH_AT) begin
					phase_n = PH_HOST;
					tag     = TAG_DELIM;
				end else if (held_q == CH_SPACE) begin
					phase_n = PH_CMD;
					tag     = TAG_DELIM;
				end else if (phase_q == PH_NICK) begin
					tag = TAG_NICK;
				end else if (phase_q == PH_USER) begin
					tag = TAG_USER;
				end else begin
					tag = TAG_HOST;
				end
			end
			PH_CMD: begin
				if (held_q == CH_SPACE) begin
					phase_n = PH_MIDDLE;
					tag     = TAG_DELIM;
				end
			end
			PH_MIDDLE: begin
				if (held_q == CH_COLON) begin
					phase_n = PH_TRAIL;
					tag     = TAG_DELIM;
				end else if (held_q == CH_SPACE && in_byte == CH_COLON) begin
					tag = TAG_DELIM;
				end else begin
					tag = TAG_MIDDLE;
				end
			end
			default: begin
				phase_n = PH_TRAIL;
				tag     = TAG_TRAIL;
			end
		endcase
	end

	assign len_inc   = (len_q != LEN_SAT) ? len_q + 1'b1 : len_q;
	assign over      = len_inc > {1'b0, max_line_length};
	assign is_eol    = held_valid_q && (held_q == CH_CR) && (in_byte == CH_LF);
	assign in_prefix = (phase_q == PH_NICK) || (phase_q == PH_USER) || (phase_q == PH_HOST);
	assign status    = ovf_q ? ST_LONG : (in_prefix ? ST_NOCMD : ST_OK);

	always_comb begin
		wr.push = accept && held_valid_q;
		if (is_eol) begin
			wr.entry.out_byte    = 8'h00;
			wr.entry.field_tag   = TAG_DELIM;
			wr.entry.end_of_line = 1'b1;
			wr.entry.line_status = status;
		end else begin
			wr.entry.out_byte    = held_q;
			wr.entry.field_tag   = tag;
			wr.entry.end_of_line = 1'b0;
			wr.entry.line_status = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_valid_q <= 1'b0;
			phase_q      <= PH_START;
			len_q        <= '0;
			ovf_q        <= 1'b0;
		end else if (accept) begin
			if (is_eol) begin
				held_valid_q <= 1'b0;
				phase_q      <= PH_START;
				len_q        <= '0;
				ovf_q        <= 1'b0;
			end else if (held_valid_q) begin
				phase_q <= phase_n;
				len_q   <= len_inc;
				ovf_q   <= ovf_q | over;
			end else begin
				held_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			held_q <= in_byte;
		end
	end

	`include "irc_line_framer_tokenizer_assert.svh"

	`ILFT_ASSERT_NEXT(a_eol_clears_hold, wr.push && wr.entry.end_of_line, !held_valid_q)
	`ILFT_ASSERT_IMPL(a_phase_needs_hold, phase_q != PH_START, held_valid_q)
	`ILFT_ASSERT_IMPL(a_len_needs_hold, len_q != '0, held_valid_q)

endmodule

// ----- rtl/ilft_back.sv -----
// ---------------------------------------------------------------------------
// ilft_back
// short result queue between the tagger and the result channel
// ---------------------------------------------------------------------------
module ilft_back #(
	parameter int unsigned DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ilft_pkg::queue_wr_t wr,
	output logic                space,
	output logic                result_valid,
	input  logic                result_ready,
	output logic [7:0]          out_byte,
	output logic [2:0]          field_tag,
	output logic                end_of_line,
	output logic [1:0]          line_status
);
	import ilft_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);
	localparam logic [PTR_W-1:0] LAST_PTR   = PTR_W'(DEPTH - 1);

	result_t          mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             full;
	logic             push;
	logic             pop;
	result_t          head;

	assign full         = count_q == FULL_COUNT;
	assign space        = !full;
	assign push         = wr.push;
	assign result_valid = count_q != '0;
	assign pop          = result_valid && result_ready;
	assign head         = mem_q[rd_ptr_q];
	assign out_byte     = head.out_byte;
	assign field_tag    = head.field_tag;
	assign end_of_line  = head.end_of_line;
	assign line_status  = head.line_status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr.entry;
		end
	end

	`include "irc_line_framer_tokenizer_assert.svh"

	`ILFT_ASSERT_IMPL(a_no_overrun, push, !full)
	`ILFT_ASSERT_IMPL(a_count_range, 1'b1, count_q <= FULL_COUNT)
	`ILFT_ASSERT_NEXT(a_stall_holds_count, result_valid && !result_ready && !push, $stable(count_q))

endmodule

// ----- rtl/irc_line_framer_tokenizer.sv -----
// ---------------------------------------------------------------------------
// irc_line_framer_tokenizer
// frames an irc byte stream at cr lf and tags each byte with its message field
// ---------------------------------------------------------------------------
// tagging: a byte is tagged when the following byte is accepted, and its
//   transaction is pushed into the result queue that feeds the result channel
// throughput: one byte per cycle while the QUEUE_DEPTH result queue has space,
//   set by the combinational tagger; the queue absorbs result channel stalls
// reset: asynchronous, clears the held-byte flag, phase, length, queue and
//   sets max_line_length to 512
module irc_line_framer_tokenizer #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        byte_valid,
	output logic        byte_ready,
	input  logic [7:0]  in_byte,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [7:0]  out_byte,
	output logic [2:0]  field_tag,
	output logic        end_of_line,
	output logic [1:0]  line_status
);
	import ilft_pkg::*;

	logic [LIMIT_W-1:0] max_len_q;
	logic               space;
	logic               accept;
	queue_wr_t          wr;

	assign pready = 1'b1;
	assign accept = byte_valid && byte_ready;
	assign byte_ready = space;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= LIMIT_RESET;
		end else if (psel && penable && pwrite && pready
				&& paddr[2] == REG_MAX_LINE_LENGTH) begin
			max_len_q <= pwdata[LIMIT_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_MAX_LINE_LENGTH) ? {{(32-LIMIT_W){1'b0}}, max_len_q}
		: 32'h0;

	ilft_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.accept          (accept),
		.in_byte         (in_byte),
		.max_line_length (max_len_q),
		.wr              (wr)
	);

	ilft_back #(
		.DEPTH (QUEUE_DEPTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr           (wr),
		.space        (space),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.out_byte     (out_byte),
		.field_tag    (field_tag),
		.end_of_line  (end_of_line),
		.line_status  (line_status)
	);

endmodule
